### design/pf_pkg.sv
// ----------------------------------------------------------------------------
// pf_pkg
// Shared types, constants and helpers for the playfair encrypt block.
// ----------------------------------------------------------------------------
`default_nettype none

package pf_pkg;

  // letter codes, 0 is A
  localparam logic [4:0] LETTER_I = 5'd8;
  localparam logic [4:0] LETTER_J = 5'd9;
  localparam logic [4:0] LETTER_Q = 5'd16;
  localparam logic [4:0] LETTER_X = 5'd23;
  localparam logic [4:0] LETTER_Z = 5'd25;

  localparam int Alpha = 26;
  localparam int Side  = 5;
  localparam int Cells = 25;

  // default queue depths
  localparam int PAIR_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF  = 4;

  // request kinds
  localparam logic [1:0] KIND_KEY    = 2'd0;
  localparam logic [1:0] KIND_FINISH = 2'd1;
  localparam logic [1:0] KIND_MSG    = 2'd2;

  // one letter pair, also the layout of one result
  typedef struct packed {
    logic [4:0] first;
    logic [4:0] second;
    logic       eom;
  } pair_t;

  // key square write from front to back
  typedef struct packed {
    logic       en;
    logic [4:0] slot;
    logic [4:0] letter;
  } wr_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_ITEM,
    F_WALK,
    F_EMIT2
  } front_state_t;

  // clamp to Z and fold J into I
  function automatic logic [4:0] pf_norm(input logic [4:0] v);
    logic [4:0] c;
    begin
      c = (v > LETTER_Z) ? LETTER_Z : v;
      if (c == LETTER_J) c = LETTER_I;
      return c;
    end
  endfunction

  // row of a square cell
  function automatic logic [2:0] pf_row(input logic [4:0] p);
    logic [2:0] r;
    begin
      if (p < 5'd5)       r = 3'd0;
      else if (p < 5'd10) r = 3'd1;
      else if (p < 5'd15) r = 3'd2;
      else if (p < 5'd20) r = 3'd3;
      else                r = 3'd4;
      return r;
    end
  endfunction

  // column of a square cell
  function automatic logic [2:0] pf_col(input logic [4:0] p);
    logic [4:0] base;
    logic [4:0] d;
    begin
      case (pf_row(p))
        3'd0:    base = 5'd0;
        3'd1:    base = 5'd5;
        3'd2:    base = 5'd10;
        3'd3:    base = 5'd15;
        default: base = 5'd20;
      endcase
      d = p - base;
      return (d > 5'd4) ? 3'd4 : d[2:0];
    end
  endfunction

  // step a row or column with wrap
  function automatic logic [2:0] pf_next(input logic [2:0] r);
    begin
      return (r == 3'(Side - 1)) ? 3'd0 : 3'(r + 3'd1);
    end
  endfunction

  // cell index from row and column
  function automatic logic [4:0] pf_cell(input logic [2:0] r, input logic [2:0] c);
    begin
      return 5'({r, 2'b00}) + {2'b00, r} + {2'b00, c};
    end
  endfunction

endpackage

`default_nettype wire

### design/playfair_encrypt.sv
// ----------------------------------------------------------------------------
// playfair_encrypt
// Playfair encryption with a 5x5 key square built from keyword requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter through a queue-style port: in_kind, in_letter, in_last
//   are taken at a clock edge with push high and full low. Kind 0 adds a
//   keyword letter, kind 1 completes the square, kind 2 is a message letter.
//   Results (one ciphertext pair each) leave through a second queue port:
//   a pair is on out_* while empty is low and is taken with pop.
//   The front takes no new request until it has handled the last one; a
//   doubled last letter needs an extra state for its padded tail pair.
//   A finish request walks the alphabet, one letter a cycle, with full high.
//   Key requests first wait until every pair in flight has read the square.
//   A pair reaches the result port from the request that completes it
//   through the pair queue and the two lookup stages.
//   Reset (rst_n low, synchronous) empties both queues and forgets the key.
//   When the receiver stalls, the result queue fills, the lookup stops
//   taking pairs, the pair queue fills and then full stays high.
// ----------------------------------------------------------------------------
`default_nettype none

module playfair_encrypt #(
  parameter int PAIR_DEPTH = pf_pkg::PAIR_DEPTH_DEF,
  parameter int OUT_DEPTH  = pf_pkg::OUT_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] in_kind,
  input  wire logic [4:0] in_letter,
  input  wire logic       in_last,
  output logic            empty,
  input  wire logic       pop,
  output logic [4:0]      out_first_out,
  output logic [4:0]      out_second_out,
  output logic            out_end_of_message
);

  localparam int PairW = $bits(pf_pkg::pair_t);

  pf_pkg::wr_t   wr;
  pf_pkg::pair_t fq_wdata, fq_rdata, oq_wdata, oq_rdata;
  logic          fq_push, fq_full, fq_pop, fq_empty;
  logic          oq_push, oq_full;
  logic          back_idle;
  logic [$clog2(PAIR_DEPTH+1)-1:0] fq_count;
  logic [$clog2(OUT_DEPTH+1)-1:0]  oq_count;

  // request intake, key building and pairing
  pf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (push),
    .in_full   (full),
    .in_kind   (in_kind),
    .in_letter (in_letter),
    .in_last   (in_last),
    .q_full    (fq_full),
    .back_idle (back_idle),
    .q_push    (fq_push),
    .q_data    (fq_wdata),
    .wr        (wr)
  );

  // pair queue between front and back
  pf_fifo #(
    .WIDTH (PairW),
    .DEPTH (PAIR_DEPTH)
  ) u_pair_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fq_push),
    .wr_data (fq_wdata),
    .full    (fq_full),
    .pop     (fq_pop),
    .rd_data (fq_rdata),
    .empty   (fq_empty),
    .count   (fq_count)
  );

  // square lookup
  pf_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .q_empty   (fq_empty),
    .q_data    (fq_rdata),
    .q_pop     (fq_pop),
    .out_count (oq_count),
    .o_push    (oq_push),
    .o_data    (oq_wdata),
    .back_idle (back_idle)
  );

  // result queue
  pf_fifo #(
    .WIDTH (PairW),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (oq_push),
    .wr_data (oq_wdata),
    .full    (oq_full),
    .pop     (pop),
    .rd_data (oq_rdata),
    .empty   (empty),
    .count   (oq_count)
  );

  assign out_first_out      = oq_rdata.first;
  assign out_second_out     = oq_rdata.second;
  assign out_end_of_message = oq_rdata.eom;

  // result credit never lets the lookup overrun the result queue
  a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    oq_push |-> !oq_full)
    else $error("result queue written while full");

  // the key square only changes with no pair in flight
  a_key_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> back_idle)
    else $error("key square written while lookup busy");

  // pair queue occupancy stays in range
  a_pair_count: assert property (@(posedge clk) disable iff (!rst_n)
    fq_count <= ($clog2(PAIR_DEPTH+1))'(PAIR_DEPTH))
    else $error("pair queue count out of range");

  // an accepted request always makes the front busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full) |=> full)
    else $error("front took a second request without classifying");

endmodule

`default_nettype wire

### design/pf_fifo.sv
// ----------------------------------------------------------------------------
// pf_fifo
// Small register queue with occupancy count, used as the pair and result queues.
// ----------------------------------------------------------------------------
`default_nettype none

module pf_fifo #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,
  input  wire logic [WIDTH-1:0]             wr_data,
  output logic                              full,
  input  wire logic                         pop,
  output logic [WIDTH-1:0]                  rd_data,
  output logic                              empty,
  output logic [$clog2(DEPTH+1)-1:0]        count
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CntW'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rd_data = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : PtrW'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : PtrW'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_nxt = CntW'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = CntW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

### design/pf_front.sv
// ----------------------------------------------------------------------------
// pf_front
// Accepts requests, builds the key square and pairs message letters.
// ----------------------------------------------------------------------------
`default_nettype none

module pf_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_push,
  output logic               in_full,
  input  wire logic [1:0]    in_kind,
  input  wire logic [4:0]    in_letter,
  input  wire logic          in_last,
  input  wire logic          q_full,
  input  wire logic          back_idle,
  output logic               q_push,
  output pf_pkg::pair_t      q_data,
  output pf_pkg::wr_t        wr
);

  pf_pkg::front_state_t state_r, state_nxt;

  logic [1:0]  kind_r, kind_nxt;
  logic [4:0]  letter_r, letter_nxt;
  logic        last_r, last_nxt;
  logic [25:0] used_r, used_nxt;
  logic [4:0]  fill_r, fill_nxt;
  logic        complete_r, complete_nxt;
  logic [4:0]  held_r, held_nxt;
  logic        held_v_r, held_v_nxt;
  logic [4:0]  walk_r, walk_nxt;
  logic        pl_en;
  logic [4:0]  pl_letter;

  assign in_full = (state_r != pf_pkg::F_IDLE);

  // next state, pairing and key placement
  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    letter_nxt   = letter_r;
    last_nxt     = last_r;
    used_nxt     = used_r;
    fill_nxt     = fill_r;
    complete_nxt = complete_r;
    held_nxt     = held_r;
    held_v_nxt   = held_v_r;
    walk_nxt     = walk_r;
    pl_en        = 1'b0;
    pl_letter    = letter_r;
    q_push       = 1'b0;
    q_data       = '0;
    wr           = '0;

    unique case (state_r)
      pf_pkg::F_IDLE: begin
        if (in_push) begin
          kind_nxt   = in_kind;
          letter_nxt = pf_pkg::pf_norm(in_letter);
          last_nxt   = in_last;
          state_nxt  = pf_pkg::F_ITEM;
        end
      end

      pf_pkg::F_ITEM: begin
        unique case (kind_r)
          pf_pkg::KIND_KEY: begin
            // key changes wait until no pair is in flight
            if (back_idle) begin
              if (complete_r) begin
                used_nxt     = '0;
                fill_nxt     = '0;
                complete_nxt = 1'b0;
                held_v_nxt   = 1'b0;
              end
              pl_en     = 1'b1;
              pl_letter = letter_r;
              state_nxt = pf_pkg::F_IDLE;
            end
          end
          pf_pkg::KIND_FINISH: begin
            if (complete_r) begin
              state_nxt = pf_pkg::F_IDLE;
            end else if (back_idle) begin
              walk_nxt  = '0;
              state_nxt = pf_pkg::F_WALK;
            end
          end
          pf_pkg::KIND_MSG: begin
            if (!complete_r) begin
              state_nxt = pf_pkg::F_IDLE;
            end else if (!q_full) begin
              state_nxt = pf_pkg::F_IDLE;
              if (held_v_r) begin
                q_push = 1'b1;
                if (letter_r != held_r) begin
                  q_data     = '{first: held_r, second: letter_r, eom: last_r};
                  held_v_nxt = 1'b0;
                end else begin
                  // doubled letter, split with filler
                  q_data = '{first: held_r,
                             second: (held_r == pf_pkg::LETTER_X) ?
                                     pf_pkg::LETTER_Q : pf_pkg::LETTER_X,
                             eom: 1'b0};
                  if (last_r) begin
                    held_v_nxt = 1'b0;
                    state_nxt  = pf_pkg::F_EMIT2;
                  end else begin
                    held_nxt   = letter_r;
                    held_v_nxt = 1'b1;
                  end
                end
              end else if (last_r) begin
                q_push = 1'b1;
                q_data = '{first: letter_r, second: pf_pkg::LETTER_X, eom: 1'b1};
              end else begin
                held_nxt   = letter_r;
                held_v_nxt = 1'b1;
              end
            end
          end
          default: begin
            state_nxt = pf_pkg::F_IDLE;
          end
        endcase
      end

      pf_pkg::F_WALK: begin
        // one alphabet letter per cycle, J skipped
        pl_en     = (walk_r != pf_pkg::LETTER_J);
        pl_letter = walk_r;
        if (walk_r == pf_pkg::LETTER_Z) begin
          complete_nxt = 1'b1;
          state_nxt    = pf_pkg::F_IDLE;
        end else begin
          walk_nxt = 5'(walk_r + 5'd1);
        end
      end

      pf_pkg::F_EMIT2: begin
        // padded tail of a doubled last letter
        if (!q_full) begin
          q_push    = 1'b1;
          q_data    = '{first: letter_r, second: pf_pkg::LETTER_X, eom: 1'b1};
          state_nxt = pf_pkg::F_IDLE;
        end
      end

      default: begin
        state_nxt = pf_pkg::F_IDLE;
      end
    endcase

    // place a letter in the next free cell
    if (pl_en && !used_nxt[pl_letter] && (fill_nxt < 5'(pf_pkg::Cells))) begin
      wr.en                = 1'b1;
      wr.slot              = fill_nxt;
      wr.letter            = pl_letter;
      used_nxt[pl_letter]  = 1'b1;
      fill_nxt             = 5'(fill_nxt + 5'd1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= pf_pkg::F_IDLE;
      used_r     <= '0;
      fill_r     <= '0;
      complete_r <= 1'b0;
      held_v_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      used_r     <= used_nxt;
      fill_r     <= fill_nxt;
      complete_r <= complete_nxt;
      held_v_r   <= held_v_nxt;
    end
  end

  // request and pairing payload
  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    letter_r <= letter_nxt;
    last_r   <= last_nxt;
    held_r   <= held_nxt;
    walk_r   <= walk_nxt;
  end

endmodule

`default_nettype wire

### design/pf_back.sv
// ----------------------------------------------------------------------------
// pf_back
// Holds the key square and enciphers letter pairs in a two stage lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module pf_back #(
  parameter int OUT_DEPTH = pf_pkg::OUT_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire pf_pkg::wr_t                    wr,
  input  wire logic                           q_empty,
  input  wire pf_pkg::pair_t                  q_data,
  output logic                                q_pop,
  input  wire logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                                o_push,
  output pf_pkg::pair_t                       o_data,
  output logic                                back_idle
);

  localparam int CntW = $clog2(OUT_DEPTH + 1);

  logic [4:0] sq_mem  [pf_pkg::Cells];
  logic [4:0] pos_mem [pf_pkg::Alpha];

  logic          v1_r, v2_r;
  logic [4:0]    pa_r, pb_r;
  logic          eom1_r, eom2_r;
  logic [4:0]    oa_r, ob_r;
  logic [CntW:0] pending;
  logic [2:0]    ra, ca, rb, cb;
  logic [4:0]    addr_a, addr_b;

  // take a pair only when its result has a guaranteed slot
  assign pending   = {1'b0, out_count} + (CntW + 1)'(v1_r) + (CntW + 1)'(v2_r);
  assign q_pop     = !q_empty && (pending < (CntW + 1)'(OUT_DEPTH));
  assign back_idle = q_empty && !v1_r && !v2_r;

  // rows and columns of both letters
  assign ra = pf_pkg::pf_row(pa_r);
  assign ca = pf_pkg::pf_col(pa_r);
  assign rb = pf_pkg::pf_row(pb_r);
  assign cb = pf_pkg::pf_col(pb_r);

  // playfair rule: row shift, column shift or rectangle corners
  always_comb begin
    if (ra == rb) begin
      addr_a = pf_pkg::pf_cell(ra, pf_pkg::pf_next(ca));
      addr_b = pf_pkg::pf_cell(rb, pf_pkg::pf_next(cb));
    end else if (ca == cb) begin
      addr_a = pf_pkg::pf_cell(pf_pkg::pf_next(ra), ca);
      addr_b = pf_pkg::pf_cell(pf_pkg::pf_next(rb), cb);
    end else begin
      addr_a = pf_pkg::pf_cell(ra, cb);
      addr_b = pf_pkg::pf_cell(rb, ca);
    end
  end

  // key square and letter position stores
  always_ff @(posedge clk) begin
    if (wr.en) begin
      sq_mem[wr.slot]    <= wr.letter;
      pos_mem[wr.letter] <= wr.slot;
    end
  end

  // stage one: position lookup
  always_ff @(posedge clk) begin
    if (q_pop) begin
      pa_r   <= pos_mem[q_data.first];
      pb_r   <= pos_mem[q_data.second];
      eom1_r <= q_data.eom;
    end
  end

  // stage two: square lookup
  always_ff @(posedge clk) begin
    if (v1_r) begin
      oa_r   <= sq_mem[addr_a];
      ob_r   <= sq_mem[addr_b];
      eom2_r <= eom1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= q_pop;
      v2_r <= v1_r;
    end
  end

  assign o_push = v2_r;
  assign o_data = '{first: oa_r, second: ob_r, eom: eom2_r};

endmodule

`default_nettype wire
